[hdl/hbdf_pkg.sv]
// ----------------------------------------------------------------------------
// hbdf_pkg
// Shared types, widths and codes for the histogram-biased distance force block.
// ----------------------------------------------------------------------------
`default_nettype none

package hbdf_pkg;

    localparam int NUM_BINS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int POS_W  = 32;   // position component
    localparam int MAG_W  = 33;   // |P - O| per component
    localparam int R_W    = 34;   // distance
    localparam int SS_W   = 66;   // sum of squares
    localparam int MA_W   = 64;   // serial multiplier, multiplicand
    localparam int MB_W   = 34;   // serial multiplier, multiplier
    localparam int MP_W   = MA_W + MB_W;
    localparam int DD_W   = 68;   // divider dividend
    localparam int DV_W   = 34;   // divider divisor
    localparam int OUT_W  = 48;
    localparam int CNT_W  = 32;
    localparam int ACC_W  = 64;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] CFG_BIN_RECIP = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_PERIOD    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_DIST  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_DIST  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SPRING_K  = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD_TAB = 2'd0,
        OP_LOAD_CNT = 2'd1,
        OP_SAMPLE   = 2'd2,
        OP_CALC     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        MS_SQ  = 3'd0,
        MS_BIN = 3'd1,
        MS_SP1 = 3'd2,
        MS_SP2 = 3'd3,
        MS_TAB = 3'd4
    } mul_sel_t;

    typedef enum logic {
        DS_PER = 1'b0,
        DS_SPR = 1'b1
    } div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_DIFF, S_SQ_GO, S_SQ_WAIT, S_SQRT_GO, S_SQRT_WAIT,
        S_DECIDE, S_PER_GO, S_PER_WAIT, S_BIN_GO, S_BIN_WAIT, S_BIN_CHK,
        S_CNT_RD, S_CNT_WR, S_MAC_GO, S_MAC_RUN, S_MAC_DRAIN, S_TAB_GO,
        S_TAB_WAIT, S_SP1_GO, S_SP1_WAIT, S_DIV_WAIT, S_SP2_WAIT, S_OUT
    } state_t;

    typedef struct packed {
        logic     latch;
        logic     diff;
        logic     comp_clr;
        logic     comp_inc;
        logic     sq_acc;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     bin_take;
        logic     cnt_wr;
        logic     load_wr;
        logic     mac_start;
        logic     mac_issue;
        logic     store_force;
        logic     set_status;
        status_t  status;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        op_t  op;
        logic load_oob;
        logic rem_nz;
        logic r_zero;
        logic outside;
        logic bin_oob;
        logic mac_last;
        logic mac_busy;
        logic comp_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/hbdf_mul.sv]
// ----------------------------------------------------------------------------
// hbdf_mul
// Shift-add multiplier, one multiplier bit per cycle. Product holds until the
// next start.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdf_mul import hbdf_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [MA_W-1:0] a,
    input  wire logic [MB_W-1:0] b,
    output logic                 done,
    output logic [MP_W-1:0]      prod
);

    localparam int CW = $clog2(MB_W);

    logic            busy_reg, done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [MP_W-1:0] mcand_reg, acc_reg;
    logic [MB_W-1:0] mplier_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MB_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= {{MB_W{1'b0}}, a};
            mplier_reg <= b;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[MP_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MB_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

[hdl/hbdf_div.sv]
// ----------------------------------------------------------------------------
// hbdf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdf_div import hbdf_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [DD_W-1:0] dividend,
    input  wire logic [DV_W-1:0] divisor,
    output logic                 done,
    output logic [DD_W-1:0]      quotient,
    output logic [DV_W-1:0]      remainder
);

    localparam int CW = $clog2(DD_W);

    logic            busy_reg, done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DD_W-1:0] quo_reg;
    logic [DV_W-1:0] rem_reg, dsor_reg;
    logic [DV_W:0]   shifted, diff;
    logic            ge;

    assign shifted = {rem_reg, quo_reg[DD_W-1]};
    assign ge      = shifted >= {1'b0, dsor_reg};
    assign diff    = shifted - {1'b0, dsor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsor_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DV_W-1:0] : shifted[DV_W-1:0];
            quo_reg <= {quo_reg[DD_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[hdl/hbdf_sqrt.sv]
// ----------------------------------------------------------------------------
// hbdf_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdf_sqrt import hbdf_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [SS_W-1:0] radicand,
    output logic                 done,
    output logic [R_W-1:0]       root
);

    localparam int RAD_W = 2 * R_W;
    localparam int REM_W = R_W + 2;
    localparam int CW    = $clog2(R_W);

    logic             busy_reg, done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [REM_W+1:0] sh, trial;
    logic             ge;

    assign sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(R_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= {{(RAD_W - SS_W){1'b0}}, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(sh - trial) : REM_W'(sh);
            root_reg <= {root_reg[R_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[hdl/hbdf_dp.sv]
// ----------------------------------------------------------------------------
// hbdf_dp
// Datapath: input and config registers, force table and histogram memories,
// arithmetic units, MAC pipeline, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdf_dp import hbdf_pkg::*; #(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic [1:0]        s_operation,
    input  wire logic [POS_W-1:0]  s_pos_x,
    input  wire logic [POS_W-1:0]  s_pos_y,
    input  wire logic [POS_W-1:0]  s_pos_z,
    input  wire logic [POS_W-1:0]  s_origin_x,
    input  wire logic [POS_W-1:0]  s_origin_y,
    input  wire logic [POS_W-1:0]  s_origin_z,
    input  wire logic [31:0]       s_time_step,
    input  wire logic [5:0]        s_table_row,
    input  wire logic [5:0]        s_table_col,
    input  wire logic [31:0]       s_load_value,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [OUT_W-1:0]       m_force_x,
    output logic [OUT_W-1:0]       m_force_y,
    output logic [OUT_W-1:0]       m_force_z
);

    localparam int BW    = $clog2(NUM_BINS);
    localparam int TDEP  = NUM_BINS * NUM_BINS;
    localparam int TAW   = $clog2(TDEP);
    localparam int SH2   = 2 * FRAC_BITS;

    // config
    logic [31:0] recip_reg;
    logic [15:0] period_reg;
    logic [30:0] min_reg, max_reg;
    logic [31:0] k_reg;

    // latched item
    op_t              op_reg;
    logic [POS_W-1:0] pos_reg [3];
    logic [POS_W-1:0] org_reg [3];
    logic [31:0]      time_reg;
    logic [5:0]       row_reg, col_reg;
    logic [31:0]      val_reg;

    logic [MAG_W-1:0] mag_reg [3];
    logic [2:0]       neg_reg;
    logic [1:0]       comp_reg;
    logic [SS_W-1:0]  ssum_reg;
    logic [BW-1:0]    bin_reg;

    // memories
    logic [31:0]       tab_mem [TDEP];
    logic [31:0]       tab_rdata_reg;
    logic [TAW-1:0]    tab_waddr, tab_raddr;
    logic [CNT_W-1:0]  cnt_mem [NUM_BINS];
    logic [NUM_BINS-1:0] cnt_vld_reg;
    logic [CNT_W-1:0]  cnt_rdata_reg;
    logic              cnt_rvld_reg;
    logic [BW-1:0]     cnt_raddr;
    logic [CNT_W-1:0]  cnt_cur, cnt_inc;
    logic              cnt_we;
    logic [BW-1:0]     cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;

    // MAC
    logic [BW-1:0]    idx_reg;
    logic             p1_reg, p2_reg;
    logic [ACC_W-1:0] prod_reg, acc_reg;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] fm;
    logic             fneg;

    // results
    status_t          status_reg;
    logic [OUT_W-1:0] force_reg [3];
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [OUT_W-1:0] m_force_reg [3];

    // units
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic            mul_done;
    logic [MP_W-1:0] mul_p;
    logic [DD_W-1:0] div_dd, div_q;
    logic [DV_W-1:0] div_dv, div_r;
    logic            div_done;
    logic            sqrt_done;
    logic [R_W-1:0]  root;

    logic             gt, lt, dneg, force_neg;
    logic [R_W-1:0]   dm;
    logic [15:0]      period;
    logic [MAG_W-1:0] mag_cur;
    logic             load_oob;

    function automatic logic [OUT_W-1:0] pack_force(input logic [MP_W-1:0] p,
                                                    input logic neg);
        logic [MP_W-1:0]  q;
        logic [OUT_W-1:0] cap, m;
        q   = p >> FRAC_BITS;
        cap = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        m   = (q > MP_W'(cap)) ? cap : q[OUT_W-1:0];
        return neg ? OUT_W'(-m) : m;
    endfunction

    // ---- config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg  <= 32'd65536;
            period_reg <= 16'd1;
            min_reg    <= '0;
            max_reg    <= '1;
            k_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BIN_RECIP: recip_reg  <= cfg_wdata;
                CFG_PERIOD:    period_reg <= cfg_wdata[15:0];
                CFG_MIN_DIST:  min_reg    <= cfg_wdata[30:0];
                CFG_MAX_DIST:  max_reg    <= cfg_wdata[30:0];
                CFG_SPRING_K:  k_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- item capture and per-component differences
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg     <= op_t'(s_operation);
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            org_reg[0] <= s_origin_x;
            org_reg[1] <= s_origin_y;
            org_reg[2] <= s_origin_z;
            time_reg   <= s_time_step;
            row_reg    <= s_table_row;
            col_reg    <= s_table_col;
            val_reg    <= s_load_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            for (int i = 0; i < 3; i++) begin
                logic [MAG_W-1:0] d;
                d = {pos_reg[i][POS_W-1], pos_reg[i]} - {org_reg[i][POS_W-1], org_reg[i]};
                neg_reg[i] <= d[MAG_W-1];
                mag_reg[i] <= d[MAG_W-1] ? MAG_W'(-d) : d;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.comp_clr) begin
            comp_reg <= '0;
        end else if (cmd.comp_inc) begin
            comp_reg <= comp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            ssum_reg <= '0;
        end else if (cmd.sq_acc) begin
            ssum_reg <= ssum_reg + mul_p[SS_W-1:0];
        end
    end

    assign mag_cur = mag_reg[comp_reg];

    // ---- spring terms
    assign gt      = root > {3'd0, max_reg};
    assign lt      = root < {3'd0, min_reg};
    assign dneg    = gt;
    assign dm      = gt ? root - {3'd0, max_reg} : {3'd0, min_reg} - root;
    assign period  = (period_reg == '0) ? 16'd1 : period_reg;

    // ---- table result magnitude
    assign fneg = acc_reg[ACC_W-1];
    assign fm   = fneg ? ACC_W'(-acc_reg) : acc_reg;

    assign force_neg = ((gt | lt) ? dneg : fneg) ^ neg_reg[comp_reg];

    // ---- arithmetic units
    always_comb begin
        unique case (cmd.mul_sel)
            MS_SQ:   begin mul_a = MA_W'(mag_cur);   mul_b = MB_W'(mag_cur);     end
            MS_BIN:  begin mul_a = MA_W'(recip_reg); mul_b = root;               end
            MS_SP1:  begin mul_a = MA_W'(dm);        mul_b = MB_W'(mag_cur);     end
            MS_SP2:  begin mul_a = MA_W'(k_reg);     mul_b = div_q[MB_W-1:0];    end
            MS_TAB:  begin mul_a = fm;               mul_b = MB_W'(mag_cur);     end
            default: begin mul_a = '0;               mul_b = '0;                 end
        endcase
    end

    always_comb begin
        unique case (cmd.div_sel)
            DS_PER: begin div_dd = DD_W'(time_reg);     div_dv = DV_W'(period); end
            DS_SPR: begin div_dd = mul_p[DD_W-1:0];     div_dv = root;          end
            default: begin div_dd = '0;                 div_dv = '0;            end
        endcase
    end

    hbdf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    hbdf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dd),
        .divisor   (div_dv),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    hbdf_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (ssum_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // ---- bin from r * recip
    always_ff @(posedge aclk) begin
        if (cmd.bin_take) begin
            bin_reg <= mul_p[SH2 +: BW];
        end
    end

    // ---- force table memory
    assign load_oob  = (int'(col_reg) >= NUM_BINS) ||
                       (op_reg == OP_LOAD_TAB && int'(row_reg) >= NUM_BINS);
    assign tab_waddr = TAW'(int'(row_reg) * NUM_BINS + int'(col_reg));
    assign tab_raddr = TAW'(int'(bin_reg) * NUM_BINS + int'(idx_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && op_reg == OP_LOAD_TAB) begin
            tab_mem[tab_waddr] <= val_reg;
        end
        tab_rdata_reg <= tab_mem[tab_raddr];
    end

    // ---- histogram memory, valid bit per bin for the reset-to-zero contents
    assign cnt_raddr = cmd.mac_issue ? idx_reg : bin_reg;
    assign cnt_cur   = cnt_rvld_reg ? cnt_rdata_reg : '0;
    assign cnt_inc   = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
    assign cnt_we    = (cmd.load_wr && op_reg == OP_LOAD_CNT) || cmd.cnt_wr;
    assign cnt_waddr = cmd.cnt_wr ? bin_reg : BW'(col_reg);
    assign cnt_wdata = cmd.cnt_wr ? cnt_inc : val_reg;

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg  <= '0;
            cnt_rvld_reg <= 1'b0;
        end else begin
            cnt_rvld_reg <= cnt_vld_reg[cnt_raddr];
            if (cnt_we) begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
        end
    end

    // ---- MAC pipeline: read, multiply, saturating accumulate
    assign acc_sum = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
        end else begin
            p1_reg <= cmd.mac_issue;
            p2_reg <= p1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_start) begin
            idx_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (cmd.mac_issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (p1_reg) begin
                prod_reg <= ACC_W'($signed(tab_rdata_reg) * $signed({1'b0, cnt_cur}));
            end
            if (p2_reg) begin
                if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
                    acc_reg <= acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                              : {1'b0, {(ACC_W-1){1'b1}}};
                end else begin
                    acc_reg <= acc_sum[ACC_W-1:0];
                end
            end
        end
    end

    // ---- working result
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            status_reg <= ST_OK;
            for (int i = 0; i < 3; i++) begin
                force_reg[i] <= '0;
            end
        end else begin
            if (cmd.set_status) begin
                status_reg <= cmd.status;
            end
            if (cmd.store_force) begin
                force_reg[comp_reg] <= pack_force(mul_p, force_neg);
            end
        end
    end

    // ---- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= status_reg;
            for (int i = 0; i < 3; i++) begin
                m_force_reg[i] <= force_reg[i];
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_force_x = m_force_reg[0];
    assign m_force_y = m_force_reg[1];
    assign m_force_z = m_force_reg[2];

    // ---- status to controller
    assign stat.mul_done  = mul_done;
    assign stat.div_done  = div_done;
    assign stat.sqrt_done = sqrt_done;
    assign stat.op        = op_reg;
    assign stat.load_oob  = load_oob;
    assign stat.rem_nz    = div_r != '0;
    assign stat.r_zero    = root == '0;
    assign stat.outside   = gt | lt;
    assign stat.bin_oob   = (mul_p >> SH2) >= MP_W'(NUM_BINS);
    assign stat.mac_last  = idx_reg == BW'(NUM_BINS - 1);
    assign stat.mac_busy  = p1_reg | p2_reg;
    assign stat.comp_last = comp_reg == 2'd2;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

[hdl/hbdf_ctrl.sv]
// ----------------------------------------------------------------------------
// hbdf_ctrl
// Controller: sequences one word through load, distance, sampling or force paths.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdf_ctrl import hbdf_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (stat.op == OP_LOAD_TAB || stat.op == OP_LOAD_CNT) begin
                    if (stat.load_oob) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_RANGE;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                    state_next = S_OUT;
                end else begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.diff     = 1'b1;
                cmd.comp_clr = 1'b1;
                state_next   = S_SQ_GO;
            end
            S_SQ_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SQ;
                state_next    = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (stat.mul_done) begin
                    cmd.sq_acc = 1'b1;
                    if (stat.comp_last) begin
                        state_next = S_SQRT_GO;
                    end else begin
                        cmd.comp_inc = 1'b1;
                        state_next   = S_SQ_GO;
                    end
                end
            end
            S_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (stat.sqrt_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.comp_clr = 1'b1;
                priority if (stat.op == OP_SAMPLE) begin
                    state_next = S_PER_GO;
                end else if (stat.r_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_ZERO;
                    state_next     = S_OUT;
                end else if (stat.outside) begin
                    state_next = S_SP1_GO;
                end else begin
                    state_next = S_BIN_GO;
                end
            end
            S_PER_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_PER;
                state_next    = S_PER_WAIT;
            end
            S_PER_WAIT: begin
                if (stat.div_done) begin
                    state_next = stat.rem_nz ? S_OUT : S_BIN_GO;
                end
            end
            S_BIN_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_BIN;
                state_next    = S_BIN_WAIT;
            end
            S_BIN_WAIT: begin
                if (stat.mul_done) begin
                    state_next = S_BIN_CHK;
                end
            end
            S_BIN_CHK: begin
                cmd.bin_take = 1'b1;
                priority if (stat.bin_oob) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_RANGE;
                    state_next     = S_OUT;
                end else if (stat.op == OP_SAMPLE) begin
                    state_next = S_CNT_RD;
                end else begin
                    state_next = S_MAC_GO;
                end
            end
            S_CNT_RD: begin
                state_next = S_CNT_WR;
            end
            S_CNT_WR: begin
                cmd.cnt_wr = 1'b1;
                state_next = S_OUT;
            end
            S_MAC_GO: begin
                cmd.mac_start = 1'b1;
                state_next    = S_MAC_RUN;
            end
            S_MAC_RUN: begin
                cmd.mac_issue = 1'b1;
                if (stat.mac_last) begin
                    state_next = S_MAC_DRAIN;
                end
            end
            S_MAC_DRAIN: begin
                if (!stat.mac_busy) begin
                    state_next = S_TAB_GO;
                end
            end
            S_TAB_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_TAB;
                state_next    = S_TAB_WAIT;
            end
            S_TAB_WAIT: begin
                if (stat.mul_done) begin
                    cmd.store_force = 1'b1;
                    if (stat.comp_last) begin
                        state_next = S_OUT;
                    end else begin
                        cmd.comp_inc = 1'b1;
                        state_next   = S_TAB_GO;
                    end
                end
            end
            S_SP1_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SP1;
                state_next    = S_SP1_WAIT;
            end
            S_SP1_WAIT: begin
                if (stat.mul_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_SPR;
                    state_next    = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_SP2;
                    state_next    = S_SP2_WAIT;
                end
            end
            S_SP2_WAIT: begin
                if (stat.mul_done) begin
                    cmd.store_force = 1'b1;
                    if (stat.comp_last) begin
                        state_next = S_OUT;
                    end else begin
                        cmd.comp_inc = 1'b1;
                        state_next   = S_SP1_GO;
                    end
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hdl/histogram_biased_distance_force_top.sv]
// Throughput: one word at a time, next word accepted once the current one
//   is parked in the output register. Reset (aresetn low, synchronous) clears
//   config to defaults, the histogram to zero and all control; table undefined.
// ----------------------------------------------------------------------------
// histogram_biased_distance_force_top
// Distance-binned histogram with table-driven or spring restoring force.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_biased_distance_force_top import hbdf_pkg::*; #(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // config write port
    input  wire logic              cfg_wr_en,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    // input word
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_operation,
    input  wire logic [POS_W-1:0]  s_pos_x,
    input  wire logic [POS_W-1:0]  s_pos_y,
    input  wire logic [POS_W-1:0]  s_pos_z,
    input  wire logic [POS_W-1:0]  s_origin_x,
    input  wire logic [POS_W-1:0]  s_origin_y,
    input  wire logic [POS_W-1:0]  s_origin_z,
    input  wire logic [31:0]       s_time_step,
    input  wire logic [5:0]        s_table_row,
    input  wire logic [5:0]        s_table_col,
    input  wire logic [31:0]       s_load_value,
    // result word
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [OUT_W-1:0]       m_force_x,
    output logic [OUT_W-1:0]       m_force_y,
    output logic [OUT_W-1:0]       m_force_z
);

    // Where the serial work goes:
    //   - |P-O|^2 per axis on the shared shift-add multiplier, 1 bit/cycle.
    //   - square root, 2 radicand bits/cycle.
    //   - sample: step % period on the restoring divider, bin multiply.
    //   - in range: one table/count read per bin, 2-stage MAC pipeline.
    //   - spring: per axis multiply, divide by R, multiply by k.

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hbdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hbdf_dp #(
        .NUM_BINS  (NUM_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_operation  (s_operation),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_origin_x   (s_origin_x),
        .s_origin_y   (s_origin_y),
        .s_origin_z   (s_origin_z),
        .s_time_step  (s_time_step),
        .s_table_row  (s_table_row),
        .s_table_col  (s_table_col),
        .s_load_value (s_load_value),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_force_x    (m_force_x),
        .m_force_y    (m_force_y),
        .m_force_z    (m_force_z)
    );

endmodule

`default_nettype wire

[hdl/hbdf_chk.sv]
// ----------------------------------------------------------------------------
// hbdf_chk
// Port-level checker for the force block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdf_chk import hbdf_pkg::*; (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [1:0]       m_status,
    input wire logic [OUT_W-1:0] m_force_x,
    input wire logic [OUT_W-1:0] m_force_y,
    input wire logic [OUT_W-1:0] m_force_z
);

    // stalled result word holds its status and x force
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_force_x))
        else $error("result word dropped or changed under stall");

    // one word in flight: taking a word closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // error statuses carry no force
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ZERO || m_status == ST_RANGE) |->
            m_force_x == '0 && m_force_y == '0 && m_force_z == '0)
        else $error("force on error status");

    // status never takes the unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_ZERO || m_status == ST_RANGE)
        else $error("bad status code");

endmodule

bind histogram_biased_distance_force_top hbdf_chk u_hbdf_chk (.*);

`default_nettype wire
